// File: sv/dssr_pkg.sv
// Shared types, codes and helper functions of the dual servo slew ramp.
`timescale 1ns / 1ps
`default_nettype none

package dssr_pkg;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 16;
    localparam int RANGE_W = 15;
    localparam int IVL_W   = 16;
    localparam int WIDE_W  = 18;   // signed room for cur +/- delta and neutral +/- range
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK        = 3'd0,
        FUNC_NEUTRAL     = 3'd1,
        FUNC_FORWARD     = 3'd2,
        FUNC_BACKWARD    = 3'd3,
        FUNC_BOTH_UP     = 3'd4,
        FUNC_BOTH_DOWN   = 3'd5,
        FUNC_A_UP_B_DOWN = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        REG_NEUTRAL_A   = 2'd0,
        REG_NEUTRAL_B   = 2'd1,
        REG_SWING_RANGE = 2'd2
    } t_reg_idx;

    localparam logic [POS_W-1:0]   RST_NEUTRAL  = 16'd3000;
    localparam logic [RANGE_W-1:0] RST_RANGE    = 15'd1000;
    localparam logic [IVL_W-1:0]   RST_INTERVAL = 16'd10;
    localparam logic [IVL_W-1:0]   ELAPSED_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  delta;
        logic [IVL_W-1:0]  interval_ms;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic             stepped;
    } t_out_item;

    function automatic logic [POS_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic [POS_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({2'b00, 16'hFFFF})) begin
            res = 16'hFFFF;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [WIDE_W-1:0] widen_pos(input logic [POS_W-1:0] p);
        return $signed({2'b00, p});
    endfunction

    function automatic logic signed [WIDE_W-1:0] widen_rng(input logic [RANGE_W-1:0] r);
        return $signed({3'b000, r});
    endfunction

    // clamp to neutral +/- range, then saturate to the 16-bit compare range
    function automatic logic [POS_W-1:0] clamp_goal(
        input logic signed [WIDE_W-1:0] v,
        input logic [POS_W-1:0]         n,
        input logic [RANGE_W-1:0]       r
    );
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] c;
        lo = widen_pos(n) - widen_rng(r);
        hi = widen_pos(n) + widen_rng(r);
        c  = v;
        if (c < lo) begin
            c = lo;
        end
        if (c > hi) begin
            c = hi;
        end
        return sat16(c);
    endfunction

endpackage

`default_nettype wire

// File: sv/dssr_in_if.sv
// Command/tick item channel of the dual servo slew ramp.
`timescale 1ns / 1ps
`default_nettype none

interface dssr_in_if import dssr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  delta;
    logic [IVL_W-1:0]  interval_ms;

    modport source (output valid, func, delta, interval_ms, input ready);
    modport sink   (input valid, func, delta, interval_ms, output ready);
endinterface

`default_nettype wire

// File: sv/dssr_out_if.sv
// Position result item channel of the dual servo slew ramp.
`timescale 1ns / 1ps
`default_nettype none

interface dssr_out_if import dssr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic             stepped;

    modport source (output valid, pos_a, pos_b, stepped, input ready);
    modport sink   (input valid, pos_a, pos_b, stepped, output ready);
endinterface

`default_nettype wire

// File: sv/dual_servo_slew_ramp.sv
// Dual servo slew ramp: two pulse-width channels stepped one count at a time.
//
// i_in carries one item per handshake: a tick (one millisecond) or a command
// that sets both goals, the step interval and the step direction of each
// channel. o_out returns one item per input item with both current positions
// and a flag that is set when a tick reaches the step interval.
// The APB port reaches neutral_a (0x0), neutral_b (0x4) and swing_range (0x8);
// writes affect later commands only.
// An accepted item lands in the input register, and its result moves into the
// output register when that register is empty or being read, which raises o_out.valid.
// Throughput is one item per cycle while o_out is not stalled: the state update is one
// compare/clamp/increment pass between the input and output registers.
// A stalled o_out holds its item; the input register still takes one more
// item, and i_in.ready drops only when both registers are full.
// Reset restores the registers to 3000/3000/1000, puts both channels and goals
// at neutral, interval 10 ticks, elapsed count zero, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module dual_servo_slew_ramp import dssr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    dssr_in_if.sink                i_in,
    dssr_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    // configuration registers
    logic [POS_W-1:0]   r_neutral_a;
    logic [POS_W-1:0]   r_neutral_b;
    logic [RANGE_W-1:0] r_swing_range;

    // ramp state
    logic [POS_W-1:0] r_cur_a, n_cur_a;
    logic [POS_W-1:0] r_cur_b, n_cur_b;
    logic [POS_W-1:0] r_goal_a, n_goal_a;
    logic [POS_W-1:0] r_goal_b, n_goal_b;
    logic             r_dir_a_up, n_dir_a_up;
    logic             r_dir_b_up, n_dir_b_up;
    logic [IVL_W-1:0] r_interval, n_interval;
    logic [IVL_W-1:0] r_elapsed, n_elapsed;

    // pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic             adv;
    logic             in_fire;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;
    logic [IVL_W-1:0] elapsed_inc;
    logic             do_step;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            REG_NEUTRAL_A:   prdata = {16'd0, r_neutral_a};
            REG_NEUTRAL_B:   prdata = {16'd0, r_neutral_b};
            REG_SWING_RANGE: prdata = {17'd0, r_swing_range};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neutral_a   <= RST_NEUTRAL;
            r_neutral_b   <= RST_NEUTRAL;
            r_swing_range <= RST_RANGE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_NEUTRAL_A:   r_neutral_a   <= pwdata[POS_W-1:0];
                REG_NEUTRAL_B:   r_neutral_b   <= pwdata[POS_W-1:0];
                REG_SWING_RANGE: r_swing_range <= pwdata[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    assign adv         = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || adv;
    assign in_fire     = i_in.valid && i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.pos_a   = r_out.pos_a;
    assign o_out.pos_b   = r_out.pos_b;
    assign o_out.stepped = r_out.stepped;

    assign elapsed_inc = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 16'd1 : r_elapsed;
    assign do_step     = (elapsed_inc >= r_interval);

    always_comb begin
        n_cur_a    = r_cur_a;
        n_cur_b    = r_cur_b;
        n_goal_a   = r_goal_a;
        n_goal_b   = r_goal_b;
        n_interval = r_interval;
        n_elapsed  = r_elapsed;
        n_out.stepped = 1'b0;

        unique case (r_in.func)
            FUNC_TICK: begin
                n_elapsed = elapsed_inc;
                if (do_step) begin
                    n_elapsed = '0;
                    n_out.stepped = 1'b1;
                    if (r_cur_a != r_goal_a) begin
                        n_cur_a = r_dir_a_up ? r_cur_a + 16'd1 : r_cur_a - 16'd1;
                    end
                    if (r_cur_b != r_goal_b) begin
                        n_cur_b = r_dir_b_up ? r_cur_b + 16'd1 : r_cur_b - 16'd1;
                    end
                end
            end
            FUNC_NEUTRAL: begin
                n_goal_a = r_neutral_a;
                n_goal_b = r_neutral_b;
            end
            FUNC_FORWARD: begin
                n_goal_a = sat16(widen_pos(r_neutral_a) + widen_rng(r_swing_range));
                n_goal_b = sat16(widen_pos(r_neutral_b) - widen_rng(r_swing_range));
            end
            FUNC_BACKWARD: begin
                n_goal_a = sat16(widen_pos(r_neutral_a) - widen_rng(r_swing_range));
                n_goal_b = sat16(widen_pos(r_neutral_b) + widen_rng(r_swing_range));
            end
            FUNC_BOTH_UP: begin
                n_goal_a = clamp_goal(widen_pos(r_cur_a) + widen_pos(r_in.delta),
                                      r_neutral_a, r_swing_range);
                n_goal_b = clamp_goal(widen_pos(r_cur_b) + widen_pos(r_in.delta),
                                      r_neutral_b, r_swing_range);
            end
            FUNC_BOTH_DOWN: begin
                n_goal_a = clamp_goal(widen_pos(r_cur_a) - widen_pos(r_in.delta),
                                      r_neutral_a, r_swing_range);
                n_goal_b = clamp_goal(widen_pos(r_cur_b) - widen_pos(r_in.delta),
                                      r_neutral_b, r_swing_range);
            end
            FUNC_A_UP_B_DOWN: begin
                n_goal_a = clamp_goal(widen_pos(r_cur_a) + widen_pos(r_in.delta),
                                      r_neutral_a, r_swing_range);
                n_goal_b = clamp_goal(widen_pos(r_cur_b) - widen_pos(r_in.delta),
                                      r_neutral_b, r_swing_range);
            end
            default: ;  // unused code: no state change
        endcase

        // any command retimes the ramp and relatches direction
        if (r_in.func != FUNC_TICK && r_in.func <= FUNC_A_UP_B_DOWN) begin
            n_interval = r_in.interval_ms;
            n_dir_a_up = (n_goal_a > r_cur_a);
            n_dir_b_up = (n_goal_b > r_cur_b);
        end else begin
            n_dir_a_up = r_dir_a_up;
            n_dir_b_up = r_dir_b_up;
        end

        n_out.pos_a = n_cur_a;
        n_out.pos_b = n_cur_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_a     <= RST_NEUTRAL;
            r_cur_b     <= RST_NEUTRAL;
            r_goal_a    <= RST_NEUTRAL;
            r_goal_b    <= RST_NEUTRAL;
            r_dir_a_up  <= 1'b0;
            r_dir_b_up  <= 1'b0;
            r_interval  <= RST_INTERVAL;
            r_elapsed   <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_cur_a    <= n_cur_a;
                r_cur_b    <= n_cur_b;
                r_goal_a   <= n_goal_a;
                r_goal_b   <= n_goal_b;
                r_dir_a_up <= n_dir_a_up;
                r_dir_b_up <= n_dir_b_up;
                r_interval <= n_interval;
                r_elapsed  <= n_elapsed;
            end
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.func        <= i_in.func;
            r_in.delta       <= i_in.delta;
            r_in.interval_ms <= i_in.interval_ms;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // channel A never moves by more than one count per item
    a_slew_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (r_cur_a == $past(r_cur_a) || r_cur_a == $past(r_cur_a) + 16'd1 ||
             r_cur_a == $past(r_cur_a) - 16'd1))
        else $error("channel A moved more than one count");

    // a command leaves the elapsed count alone
    a_cmd_keeps_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.func != FUNC_TICK) |=> $stable(r_elapsed))
        else $error("command changed elapsed count");

    // a step clears the elapsed count
    a_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.func == FUNC_TICK && do_step) |=> (r_elapsed == '0))
        else $error("elapsed not cleared after a step");

    // both stages full and output stalled: no new item taken
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("item accepted while both stages are full");

endmodule

`default_nettype wire
